@@ sv/vdi_pkg.sv @@
package vdi_pkg;

    // vertex components and their widths
    localparam int COMP_N = 8;
    localparam int COMP_W = 32;
    localparam int TOL_W  = 16;

    // result field widths
    localparam int INDEX_W = 10;
    localparam int UCOUNT_W = 11;

    // stream payload widths
    localparam int S_TDATA_W = COMP_N * COMP_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // tolerance after reset, about 0.00005 in Q15.16
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd3;

    // per-lane table strobes driven by the scan sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lane_ctl_t;

endpackage

@@ sv/vdi_ram.sv @@
module vdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/vdi_lane.sv @@
module vdi_lane #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  vdi_pkg::lane_ctl_t            ctl,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [vdi_pkg::COMP_W-1:0]    comp,
    input  logic [vdi_pkg::TOL_W-1:0]     tol,
    output logic                          hit
);
    import vdi_pkg::*;

    logic [COMP_W-1:0]        rd_data;
    logic signed [COMP_W:0]   diff_next;
    logic signed [COMP_W:0]   diff_reg;
    logic signed [COMP_W:0]   tol_pos;
    logic signed [COMP_W:0]   tol_neg;
    logic                     hit_next;
    logic                     hit_reg;

    // this lane's column of the unique-vertex table
    vdi_ram #(
        .WIDTH (COMP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (comp),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // full-precision difference, never wraps
    always_comb
    begin
        diff_next = $signed({comp[COMP_W-1], comp}) - $signed({rd_data[COMP_W-1], rd_data});
    end

    // |diff| <= tol as a window compare
    always_comb
    begin
        tol_pos  = $signed({{(COMP_W + 1 - TOL_W){1'b0}}, tol});
        tol_neg  = -tol_pos;
        hit_next = (diff_reg <= tol_pos) && (diff_reg >= tol_neg);
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        hit_reg  <= hit_next;
    end

    assign hit = hit_reg;

endmodule

@@ sv/vertex_dedup_indexer.sv @@
// Vertex welding: one vertex in, one index out.
// Input stream: s_axis_tdata carries eight signed Q15.16 components, s_axis_tlast
// marks the final vertex of a mesh. Output stream: index, count and the new and
// overflow flags, with m_axis_tlast echoing the end-of-mesh mark.
// cfg_we writes the 16 bit tolerance; write it only while no vertex is in flight.
// Each lane holds one component column of the table and compares it against the
// incoming vertex; the lane hits are ANDed and the first full match wins.
// The table is read one entry per cycle through each lane's read port, behind a
// three-stage read/subtract/compare pipeline. A hit on entry i ends the scan there,
// a miss reads all n stored entries, and on an empty table a miss needs no read.
// The next vertex is taken only once the sequencer is back in ST_IDLE after ST_DONE.
// s_axis_tready is high only while no vertex is being scanned.
// Reset empties the table (count to zero, no clearing pass needed) and sets the
// tolerance to 3. After a transfer with tlast the table empties again.
// A finished result sits in the output register until taken; if the receiver
// stalls, the next vertex is still accepted and scanned, and its result waits
// until the output register frees up.
module vertex_dedup_indexer #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vdi_pkg::TOL_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v (32 bits each)
    input  logic [vdi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // vertex_index [9:0], unique_count [20:10], zero fill [23:21]
    output logic [vdi_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // is_new [0], overflow [1]
    output logic [vdi_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                             m_axis_tlast
);
    import vdi_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [2:0]          tag_v_reg, tag_v_next;
    logic [ADDR_W-1:0]   tag_idx_reg [3];
    logic [COMP_W-1:0]   comp_reg [COMP_N];
    logic                last_reg;

    logic [ADDR_W-1:0]   res_idx_reg, res_idx_next;
    logic                res_new_reg, res_new_next;
    logic                res_ovf_reg, res_ovf_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;

    logic                m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]  m_idx_reg;
    logic [UCOUNT_W-1:0] m_cnt_reg;
    logic                m_new_reg;
    logic                m_ovf_reg;
    logic                m_last_reg;

    logic                s_accept;
    logic                issue;
    logic                hit_now;
    logic                scan_miss;
    logic                table_full;
    logic                store;
    logic                out_free;
    logic                finish;
    logic [31:0]         res_idx_ext;
    logic [31:0]         res_cnt_ext;
    logic [COMP_N-1:0]   lane_hit;
    lane_ctl_t           lane_ctl;

    // handshake and scan control
    always_comb
    begin
        s_accept   = s_axis_tvalid && s_axis_tready;
        table_full = (count_reg == DEPTH_CNT);
        hit_now    = tag_v_reg[2] && (&lane_hit);
        issue      = (state_reg == ST_SCAN) && (rd_ptr_reg != count_reg) && !hit_now;
        scan_miss  = (state_reg == ST_SCAN) && (rd_ptr_reg == count_reg) && (tag_v_reg == 3'b000);
        store      = scan_miss && !table_full;
        out_free   = !m_valid_reg || m_axis_tready;
        finish     = (state_reg == ST_DONE) && out_free;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // lane strobes
    always_comb
    begin
        lane_ctl.rd_en = issue;
        lane_ctl.wr_en = store;
    end

    // component lanes
    for (genvar k = 0; k < COMP_N; k++)
    begin : g_lane
        vdi_lane #(
            .DEPTH (TABLE_DEPTH)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .rd_addr (rd_ptr_reg[ADDR_W-1:0]),
            .wr_addr (count_reg[ADDR_W-1:0]),
            .comp    (comp_reg[k]),
            .tol     (tol_reg),
            .hit     (lane_hit[k])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit_now || scan_miss)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters, tolerance and pipeline tags
    always_comb
    begin
        tol_next = cfg_we ? cfg_wdata : tol_reg;

        count_next = count_reg;
        if (store)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (finish && last_reg)
        begin
            count_next = '0;
        end

        rd_ptr_next = rd_ptr_reg;
        if (s_accept)
        begin
            rd_ptr_next = '0;
        end
        else if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end

        if ((state_reg != ST_SCAN) || hit_now)
        begin
            tag_v_next = 3'b000;
        end
        else
        begin
            tag_v_next = {tag_v_reg[1:0], issue};
        end

        m_valid_next = m_valid_reg;
        if (finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // merge: first full match, else append or overflow
    always_comb
    begin
        res_idx_next = res_idx_reg;
        res_new_next = res_new_reg;
        res_ovf_next = res_ovf_reg;
        res_cnt_next = res_cnt_reg;
        if (hit_now)
        begin
            res_idx_next = tag_idx_reg[2];
            res_new_next = 1'b0;
            res_ovf_next = 1'b0;
            res_cnt_next = count_reg;
        end
        else if (scan_miss)
        begin
            if (table_full)
            begin
                res_idx_next = '0;
                res_new_next = 1'b0;
                res_ovf_next = 1'b1;
                res_cnt_next = count_reg;
            end
            else
            begin
                res_idx_next = count_reg[ADDR_W-1:0];
                res_new_next = 1'b1;
                res_ovf_next = 1'b0;
                res_cnt_next = count_reg + CNT_W'(1);
            end
        end
    end

    // fit result to field widths
    always_comb
    begin
        res_idx_ext = 32'(res_idx_reg);
        res_cnt_ext = 32'(res_cnt_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tol_reg     <= TOL_RESET;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            tag_v_reg   <= 3'b000;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tol_reg     <= tol_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            tag_v_reg   <= tag_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            for (int k = 0; k < COMP_N; k++)
            begin
                comp_reg[k] <= s_axis_tdata[k*COMP_W +: COMP_W];
            end
            last_reg <= s_axis_tlast;
        end

        tag_idx_reg[0] <= rd_ptr_reg[ADDR_W-1:0];
        tag_idx_reg[1] <= tag_idx_reg[0];
        tag_idx_reg[2] <= tag_idx_reg[1];

        res_idx_reg <= res_idx_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        res_cnt_reg <= res_cnt_next;

        if (finish)
        begin
            m_idx_reg  <= res_idx_ext[INDEX_W-1:0];
            m_cnt_reg  <= res_cnt_ext[UCOUNT_W-1:0];
            m_new_reg  <= res_new_reg;
            m_ovf_reg  <= res_ovf_reg;
            m_last_reg <= last_reg;
        end
    end

    // output transfer
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - INDEX_W - UCOUNT_W){1'b0}}, m_cnt_reg, m_idx_reg};
    assign m_axis_tuser  = {m_ovf_reg, m_new_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

@@ test/weld_checker.sv @@
module weld_checker
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TOL_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   outstanding
);

    // one result of the welding lookup
    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic                is_new;
        logic                overflow;
        logic [UCOUNT_W-1:0] count;
        logic                last;
    } weld_result_t;

    // shadow copy of the unique-vertex table and its settings
    logic [S_TDATA_W-1:0] weld_table [TABLE_DEPTH];
    int                   stored;
    logic [TOL_W-1:0]     tol;
    weld_result_t         weld_q [$];
    weld_result_t         got;
    weld_result_t         want;
    int                   result_no;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        result_no   = 0;
        stored      = 0;
        tol         = TOL_RESET;
    end

    // first stored entry within tolerance on every component, else append
    function automatic weld_result_t weld_lookup(input logic [S_TDATA_W-1:0] vtx,
                                                 input logic last);
        weld_result_t res;
        int           hit;
        longint       a;
        longint       b;
        longint       d;
        bit           same;
        hit = -1;
        for (int i = 0; i < stored && hit < 0; i++)
        begin
            same = 1'b1;
            for (int k = 0; k < COMP_N; k++)
            begin
                // 64 bit difference so the extremes never wrap
                a = signed'(vtx[k*COMP_W +: COMP_W]);
                b = signed'(weld_table[i][k*COMP_W +: COMP_W]);
                d = a - b;
                if (d < 0)
                    d = -d;
                if (d > longint'(tol))
                    same = 1'b0;
            end
            if (same)
                hit = i;
        end
        res = '0;
        res.last = last;
        if (hit >= 0)
            res.index = hit[INDEX_W-1:0];
        else if (stored < TABLE_DEPTH)
        begin
            weld_table[stored] = vtx;
            res.index = stored[INDEX_W-1:0];
            res.is_new = 1'b1;
            stored++;
        end
        else
            res.overflow = 1'b1;
        res.count = stored[UCOUNT_W-1:0];
        // end of mesh empties the table after the result is formed
        if (last)
            stored = 0;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%t mismatch: %s", $time, msg);
    endtask

    // watch both channels and the tolerance port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weld_q.delete();
            stored      = 0;
            tol         = TOL_RESET;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                tol = cfg_wdata;
            // result transfer checked before the input transfer of the same edge
            if (m_tvalid && m_tready)
            begin
                got.index    = m_tdata[INDEX_W-1:0];
                got.count    = m_tdata[INDEX_W +: UCOUNT_W];
                got.is_new   = m_tuser[0];
                got.overflow = m_tuser[1];
                got.last     = m_tlast;
                if (weld_q.size() == 0)
                    note_failure($sformatf("result %0d with no vertex pending: index %0d",
                                           result_no, got.index));
                else
                begin
                    want = weld_q.pop_front();
                    if (got.index !== want.index || got.is_new !== want.is_new ||
                        got.overflow !== want.overflow || got.count !== want.count ||
                        got.last !== want.last)
                        note_failure($sformatf({"result %0d exp idx %0d new %0d ovf %0d ",
                            "cnt %0d last %0d, got idx %0d new %0d ovf %0d cnt %0d last %0d"},
                            result_no, want.index, want.is_new, want.overflow, want.count,
                            want.last, got.index, got.is_new, got.overflow, got.count,
                            got.last));
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
                weld_q.insert(weld_q.size(), weld_lookup(s_tdata, s_tlast));
            outstanding = weld_q.size();
        end
    end

endmodule

@@ test/tb.sv @@
module tb;

    import vdi_pkg::*;

    localparam int TABLE_DEPTH = 1024;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [TOL_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    int                   fail_count;
    int                   outstanding;
    int                   cur_tol = int'(TOL_RESET);
    bit                   calm = 1'b0;
    int                   stall_left = 0;
    int                   calm_left = 0;

    vertex_dedup_indexer #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    weld_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side stalls: short ones often, long ones rarely, calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        int  r;
        bit  rdy;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            rdy = 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (calm_left > 0)
                calm_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(100, 300);
                else if (r < 6)
                begin
                    stall_left = $urandom_range(15, 60) - 1;
                    rdy = 1'b0;
                end
                else if (r < 30)
                begin
                    stall_left = $urandom_range(1, 3) - 1;
                    rdy = 1'b0;
                end
            end
            m_axis_tready <= rdy;
        end
    end

    function automatic logic [S_TDATA_W-1:0] splat(input logic [COMP_W-1:0] c);
        return {COMP_N{c}};
    endfunction

    // components either fully random or clustered near zero
    function automatic logic [S_TDATA_W-1:0] fresh_vertex();
        logic [S_TDATA_W-1:0] v;
        for (int k = 0; k < COMP_N; k++)
        begin
            if ($urandom_range(0, 1) == 1)
                v[k*COMP_W +: COMP_W] = $urandom();
            else
                v[k*COMP_W +: COMP_W] = 32'($urandom_range(0, 128)) - 32'd64;
        end
        return v;
    endfunction

    // copy of a vertex moved around the tolerance edge on each component
    function automatic logic [S_TDATA_W-1:0] near_vertex(input logic [S_TDATA_W-1:0] base);
        logic [S_TDATA_W-1:0] v;
        int                   d;
        int                   k;
        for (k = 0; k < COMP_N; k++)
        begin
            case ($urandom_range(0, 3))
                0: d = 0;
                1: d = cur_tol;
                2: d = $urandom_range(0, 2 * cur_tol) - cur_tol;
                default: d = cur_tol;
            endcase
            if ($urandom_range(0, 1) == 1)
                d = -d;
            v[k*COMP_W +: COMP_W] = base[k*COMP_W +: COMP_W] + 32'(d);
        end
        // sometimes push one component just past the tolerance
        if ($urandom_range(0, 9) < 3)
        begin
            k = $urandom_range(0, COMP_N - 1);
            d = ($urandom_range(0, 1) == 1) ? cur_tol + 1 : -(cur_tol + 1);
            v[k*COMP_W +: COMP_W] = base[k*COMP_W +: COMP_W] + 32'(d);
        end
        return v;
    endfunction

    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one vertex transfer, then an optional idle gap
    task automatic send_vertex(input logic [S_TDATA_W-1:0] vtx, input logic last);
        int gap;
        s_axis_tdata  <= vtx;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // tolerance write once every result is out
    task automatic set_tolerance(input logic [TOL_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        cur_tol = int'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [S_TDATA_W-1:0] v;
        logic [S_TDATA_W-1:0] mesh_q [$];
        logic [TOL_W-1:0]     tol_plan [7];
        int                   mesh_len;
        int                   sent;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tolerance: edge of the tolerance, extremes, first match wins
        send_vertex(splat(32'd0), 1'b0);
        send_vertex(splat(32'd3), 1'b0);
        send_vertex(splat(-32'sd3), 1'b0);
        v = splat(32'd0);
        v[31:0] = 32'd4;
        send_vertex(v, 1'b0);
        v[31:0] = 32'd2;
        send_vertex(v, 1'b0);
        send_vertex(splat(32'h7FFF_FFFF), 1'b0);
        send_vertex(splat(32'h8000_0000), 1'b0);
        send_vertex(splat(32'h7FFF_FFFC), 1'b0);
        send_vertex(splat(32'h8000_0003), 1'b0);
        v = splat(32'd0);
        v[31:0] = -32'sd3;
        v[255:224] = 32'd3;
        send_vertex(v, 1'b0);
        v = splat(32'd0);
        v[95:64] = 32'h7FFF_FFFF;
        send_vertex(v, 1'b1);
        send_vertex(splat(32'd0), 1'b0);
        send_vertex(splat(32'd0), 1'b1);

        // exact matching only
        set_tolerance(16'd0);
        send_vertex(splat(32'd0), 1'b0);
        v = splat(32'd0);
        v[31:0] = 32'd1;
        send_vertex(v, 1'b0);
        send_vertex(splat(32'd0), 1'b0);
        send_vertex(v, 1'b1);

        // widest tolerance
        set_tolerance(16'hFFFF);
        send_vertex(splat(32'd0), 1'b0);
        send_vertex(splat(32'd65535), 1'b0);
        send_vertex(splat(-32'sd65535), 1'b0);
        v = splat(32'd0);
        v[127:96] = 32'd65536;
        send_vertex(v, 1'b0);
        v[127:96] = -32'sd65536;
        send_vertex(v, 1'b0);
        send_vertex(splat(32'h7FFF_FFFF), 1'b0);
        send_vertex(splat(32'h8000_0000), 1'b1);

        // random meshes over several tolerance settings
        tol_plan[0] = 16'd0;
        tol_plan[1] = 16'd1;
        tol_plan[2] = 16'd3;
        tol_plan[3] = 16'($urandom_range(4, 300));
        tol_plan[4] = 16'hFFFF;
        tol_plan[5] = 16'($urandom_range(0, 65535));
        tol_plan[6] = 16'($urandom_range(0, 65535));
        for (int phase = 0; phase < 7; phase++)
        begin
            set_tolerance(tol_plan[phase]);
            sent = 0;
            while (sent < 70)
            begin
                mesh_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
                calm = ($urandom_range(0, 3) == 0);
                mesh_q.delete();
                for (int j = 0; j < mesh_len; j++)
                begin
                    if (mesh_q.size() == 0 || $urandom_range(0, 9) < 4)
                        v = fresh_vertex();
                    else
                        v = near_vertex(mesh_q[$urandom_range(0, mesh_q.size() - 1)]);
                    mesh_q.insert(mesh_q.size(), v);
                    send_vertex(v, j == mesh_len - 1);
                end
                sent += mesh_len;
            end
        end

        // drain and give the verdict
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
